/* design/calendar_date_adder_macros.svh */
// ----------------------------------------------------------------------------
// calendar_date_adder_macros
// shared assertion macros for the calendar date adder blocks
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADDER_MACROS_SVH
`define CALENDAR_DATE_ADDER_MACROS_SVH

// same-cycle implication, clocked by clk, off while rst_n is low
`define CDA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by clk, off while rst_n is low
`define CDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cda_pkg.sv */
// ----------------------------------------------------------------------------
// cda_pkg
// types, constants and calendar helpers shared by the date adder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cda_pkg;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int AMT_W   = 16;
    localparam int CNT_W   = 17;   // running day count and month total
    localparam int Q_W     = 13;   // quotient of year / 100 or total / 12
    localparam int UPC_W   = 4;

    // reciprocal constants, both scaled by 2^19
    localparam int             RECIP_SHIFT = 19;
    localparam logic [15:0]    RECIP_100   = 16'd5243;
    localparam logic [15:0]    RECIP_12    = 16'd43691;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // microprogram addresses
    localparam logic [UPC_W-1:0] A_IDLE    = 4'd0;
    localparam logic [UPC_W-1:0] A_LQ1     = 4'd1;
    localparam logic [UPC_W-1:0] A_LR1     = 4'd2;
    localparam logic [UPC_W-1:0] A_PRE     = 4'd3;
    localparam logic [UPC_W-1:0] A_ADD_AMT = 4'd4;
    localparam logic [UPC_W-1:0] A_WALK    = 4'd5;
    localparam logic [UPC_W-1:0] A_LQ2     = 4'd6;
    localparam logic [UPC_W-1:0] A_LR2     = 4'd7;
    localparam logic [UPC_W-1:0] A_DONE    = 4'd8;
    localparam logic [UPC_W-1:0] A_MQ      = 4'd9;
    localparam logic [UPC_W-1:0] A_MSPLIT  = 4'd10;

    // sequencing mode of one control word
    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_DISPATCH,
        SEQ_LOOP,
        SEQ_WALK,
        SEQ_EMIT
    } seq_mode_t;

    // datapath operation of one control word
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_QUOT_YEAR,
        DP_LEAP,
        DP_ACC,
        DP_ADD_AMT,
        DP_WALK,
        DP_QUOT_MONTH,
        DP_SPLIT,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        seq_mode_t         seq;
        dp_op_t            op;
        logic [UPC_W-1:0]  target;
    } ctrl_word_t;

    // condition flags from datapath to sequencer
    typedef struct packed {
        logic in_fire;
        logic op_months;
        logic m_lt;
        logic d_gt;
        logic m_is_dec;
        logic out_free;
    } dp_flags_t;

    // length of a month, month is 1..12
    function automatic logic [DAY_W-1:0] days_in(input logic leap, input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_FEB:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:     len = 5'd30;
            default:                     len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

/* design/cda_useq.sv */
// ----------------------------------------------------------------------------
// cda_useq
// microprogram sequencer: step counter, control store and jump logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cda_useq
    import cda_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_flags_t  flags,
    output ctrl_word_t cw
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] upc_inc;

    assign upc_inc = upc_reg + 4'd1;

    // control store
    always_comb
    begin
        unique case (upc_reg)
            A_IDLE:    cw = '{seq: SEQ_DISPATCH, op: DP_LOAD,       target: A_MQ};
            A_LQ1:     cw = '{seq: SEQ_NEXT,     op: DP_QUOT_YEAR,  target: A_IDLE};
            A_LR1:     cw = '{seq: SEQ_NEXT,     op: DP_LEAP,       target: A_IDLE};
            A_PRE:     cw = '{seq: SEQ_LOOP,     op: DP_ACC,        target: A_IDLE};
            A_ADD_AMT: cw = '{seq: SEQ_NEXT,     op: DP_ADD_AMT,    target: A_IDLE};
            A_WALK:    cw = '{seq: SEQ_WALK,     op: DP_WALK,       target: A_DONE};
            A_LQ2:     cw = '{seq: SEQ_NEXT,     op: DP_QUOT_YEAR,  target: A_IDLE};
            A_LR2:     cw = '{seq: SEQ_JUMP,     op: DP_LEAP,       target: A_WALK};
            A_DONE:    cw = '{seq: SEQ_EMIT,     op: DP_EMIT,       target: A_IDLE};
            A_MQ:      cw = '{seq: SEQ_NEXT,     op: DP_QUOT_MONTH, target: A_IDLE};
            A_MSPLIT:  cw = '{seq: SEQ_JUMP,     op: DP_SPLIT,      target: A_DONE};
            default:   cw = '{seq: SEQ_JUMP,     op: DP_NOP,        target: A_IDLE};
        endcase
    end

    // next step selection
    always_comb
    begin
        unique case (cw.seq)
            SEQ_NEXT:     upc_next = upc_inc;
            SEQ_JUMP:     upc_next = cw.target;
            SEQ_DISPATCH: upc_next = flags.in_fire ? (flags.op_months ? cw.target : upc_inc)
                                                   : upc_reg;
            SEQ_LOOP:     upc_next = flags.m_lt ? upc_reg : upc_inc;
            SEQ_WALK:     upc_next = flags.d_gt ? (flags.m_is_dec ? upc_inc : upc_reg)
                                                : cw.target;
            SEQ_EMIT:     upc_next = flags.out_free ? cw.target : upc_reg;
            default:      upc_next = A_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= A_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

/* design/cda_dpath.sv */
// ----------------------------------------------------------------------------
// cda_dpath
// date datapath: working registers, shared reciprocal multiplier, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "calendar_date_adder_macros.svh"

module cda_dpath
    import cda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_word_t          cw,
    output dp_flags_t           flags,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [YEAR_W-1:0]   start_year,
    input  logic [MONTH_W-1:0]  start_month,
    input  logic [DAY_W-1:0]    start_day,
    input  logic [AMT_W-1:0]    amount,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [YEAR_W-1:0]   new_year,
    output logic [MONTH_W-1:0]  new_month,
    output logic [DAY_W-1:0]    new_day
);

    // working registers
    logic                op_reg;
    logic [YEAR_W-1:0]   y_reg;
    logic [MONTH_W-1:0]  m_reg;
    logic [MONTH_W-1:0]  tgt_reg;
    logic [CNT_W-1:0]    d_reg;
    logic [AMT_W-1:0]    amt_reg;
    logic [Q_W-1:0]      q_reg;
    logic                leap_reg;

    // result register
    logic                out_valid_reg;
    logic [YEAR_W-1:0]   new_year_reg;
    logic [MONTH_W-1:0]  new_month_reg;
    logic [DAY_W-1:0]    new_day_reg;

    logic                in_fire;
    logic [MONTH_W-1:0]  month_clamped;
    logic [DAY_W-1:0]    dim;
    logic [CNT_W-1:0]    dim_ext;
    logic [CNT_W-1:0]    month_total;
    logic [CNT_W-1:0]    mul_a;
    logic [15:0]         mul_k;
    logic [32:0]         prod;
    logic [19:0]         q_hund;
    logic [YEAR_W-1:0]   rem_100;
    logic                century;
    logic [CNT_W-1:0]    q_twelve;
    logic [CNT_W-1:0]    rem_12;
    logic                out_free;

    // input handshake, one item at a time
    assign in_stall = (cw.seq != SEQ_DISPATCH);
    assign in_fire  = in_valid && !in_stall;

    // start month forced into 1..12
    always_comb
    begin
        if (start_month < MONTH_JAN)
        begin
            month_clamped = MONTH_JAN;
        end
        else if (start_month > MONTH_DEC)
        begin
            month_clamped = MONTH_DEC;
        end
        else
        begin
            month_clamped = start_month;
        end
    end

    // month length of the walk position
    assign dim     = days_in(leap_reg, m_reg);
    assign dim_ext = {{(CNT_W-DAY_W){1'b0}}, dim};

    // zero-based month plus month amount
    assign month_total = {1'b0, amt_reg} + {{(CNT_W-MONTH_W){1'b0}}, tgt_reg - 4'd1};

    // shared reciprocal multiplier for year / 100 and total / 12
    assign mul_a = (cw.op == DP_QUOT_MONTH) ? month_total
                                            : {{(CNT_W-YEAR_W){1'b0}}, y_reg};
    assign mul_k = (cw.op == DP_QUOT_MONTH) ? RECIP_12 : RECIP_100;
    assign prod  = {16'd0, mul_a} * {17'd0, mul_k};

    // century and leap test from the registered quotient
    assign q_hund  = {7'd0, q_reg} * 20'd100;
    assign rem_100 = y_reg - q_hund[YEAR_W-1:0];
    assign century = (rem_100 == '0);

    // remainder of month total by twelve
    assign q_twelve = {4'd0, q_reg} * 17'd12;
    assign rem_12   = month_total - q_twelve;

    assign out_free = !out_valid_reg || !out_stall;

    // flags to the sequencer
    assign flags.in_fire   = in_fire;
    assign flags.op_months = op;
    assign flags.m_lt      = (m_reg < tgt_reg);
    assign flags.d_gt      = (d_reg > dim_ext);
    assign flags.m_is_dec  = (m_reg == MONTH_DEC);
    assign flags.out_free  = out_free;

    // working registers
    always_ff @(posedge clk)
    begin
        case (cw.op)
            DP_LOAD:
            begin
                if (in_fire)
                begin
                    op_reg  <= op;
                    y_reg   <= start_year;
                    tgt_reg <= month_clamped;
                    m_reg   <= MONTH_JAN;
                    d_reg   <= {{(CNT_W-DAY_W){1'b0}}, start_day};
                    amt_reg <= amount;
                end
            end
            DP_QUOT_YEAR, DP_QUOT_MONTH:
            begin
                q_reg <= prod[RECIP_SHIFT +: Q_W];
            end
            DP_LEAP:
            begin
                leap_reg <= (y_reg[1:0] == 2'b00) && (!century || (q_reg[1:0] == 2'b00));
            end
            DP_ACC:
            begin
                if (flags.m_lt)
                begin
                    d_reg <= d_reg + dim_ext;
                    m_reg <= m_reg + 4'd1;
                end
            end
            DP_ADD_AMT:
            begin
                d_reg <= d_reg + {1'b0, amt_reg};
                m_reg <= MONTH_JAN;
            end
            DP_WALK:
            begin
                if (flags.d_gt)
                begin
                    d_reg <= d_reg - dim_ext;
                    if (flags.m_is_dec)
                    begin
                        m_reg <= MONTH_JAN;
                        y_reg <= y_reg + 14'd1;
                    end
                    else
                    begin
                        m_reg <= m_reg + 4'd1;
                    end
                end
            end
            DP_SPLIT:
            begin
                m_reg <= rem_12[MONTH_W-1:0] + 4'd1;
                y_reg <= y_reg + {1'b0, q_reg};
            end
            default:
            begin
            end
        endcase
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if ((cw.op == DP_EMIT) && out_free)
        begin
            new_year_reg  <= y_reg;
            new_month_reg <= m_reg;
            new_day_reg   <= d_reg[DAY_W-1:0];
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((cw.op == DP_EMIT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_year  = new_year_reg;
    assign new_month = new_month_reg;
    assign new_day   = new_day_reg;

    // checks
    `CDA_ASSERT_NEXT(a_one_item_in_flight, in_fire, in_stall, "item accepted while busy")
    `CDA_ASSERT_IMP(a_out_month_range, out_valid_reg,
        (new_month_reg >= MONTH_JAN) && (new_month_reg <= MONTH_DEC), "result month out of range")
    `CDA_ASSERT_IMP(a_walk_finished, (cw.op == DP_EMIT) && !op_reg,
        d_reg <= dim_ext, "day count exceeds month length at emit")

endmodule

/* design/calendar_date_adder.sv */
// Gregorian date adder. Takes one item (op, start_year, start_month, start_day,
// amount) and returns one item (new_year, new_month, new_day). Add-days sums
// the month lengths before the start month, adds the amount, then walks the day
// count month by month under a small microprogram, one month per cycle through
// the shared datapath, with extra steps at each year crossing to recompute the
// leap flag; add-months divides the month total by twelve and splits it into
// years and months. One item is in work at a time; a finished result sits in an
// output register, so the next item is taken while the result waits. Years wrap
// modulo 16384 and the start month is clamped into 1..12.
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// calendar_date_adder
// top level: microprogram sequencer driving the date datapath
// ----------------------------------------------------------------------------

module calendar_date_adder
    import cda_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [YEAR_W-1:0]   start_year,
    input  logic [MONTH_W-1:0]  start_month,
    input  logic [DAY_W-1:0]    start_day,
    input  logic [AMT_W-1:0]    amount,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [YEAR_W-1:0]   new_year,
    output logic [MONTH_W-1:0]  new_month,
    output logic [DAY_W-1:0]    new_day
);

    ctrl_word_t cw;
    dp_flags_t  flags;

    // sequencer
    cda_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cw    (cw)
    );

    // datapath
    cda_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cw          (cw),
        .flags       (flags),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .start_year  (start_year),
        .start_month (start_month),
        .start_day   (start_day),
        .amount      (amount),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_year    (new_year),
        .new_month   (new_month),
        .new_day     (new_day)
    );

endmodule
